/* sv/gidu_pkg.sv */
`timescale 1ns / 1ps

package gidu_pkg;

  localparam int MaxDigitsDefault = 15;
  localparam int QueueDepth       = 2;
  localparam int SeqWidth         = 32;
  localparam int WorkerWidth      = 10;
  localparam int DigitWidth       = 8;
  localparam int CountWidth       = 4;
  localparam int DivBitsPerCycle  = 8;
  localparam int DivSteps         = SeqWidth / DivBitsPerCycle;

  typedef logic [1:0] cfg_index_t;

  localparam cfg_index_t CfgRadix        = 2'd0;
  localparam cfg_index_t CfgDeviceDigits = 2'd1;
  localparam cfg_index_t CfgTotalDigits  = 2'd2;

  typedef struct packed {
    logic [SeqWidth-1:0]    seq_number;
    logic [WorkerWidth-1:0] worker_id;
    logic [CountWidth-1:0]  gray_cnt;
    logic [CountWidth-1:0]  count;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

/* sv/gidu_front.sv */
`timescale 1ns / 1ps

module gidu_front #(
  parameter int MAX_DIGITS = gidu_pkg::MaxDigitsDefault
) (
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [31:0]            seq_number,
  input  logic [9:0]             worker_id,
  input  logic [3:0]             device_digits,
  input  logic [3:0]             total_digits,
  input  gidu_pkg::queue_status_t q_status,
  output logic                   push,
  output gidu_pkg::job_t         push_job
);
  import gidu_pkg::*;

  localparam logic [CountWidth-1:0] CntCap =
    (MAX_DIGITS > 15) ? 4'd15 : CountWidth'(MAX_DIGITS);

  logic [CountWidth-1:0] span;

  assign span     = (total_digits > device_digits) ? total_digits : device_digits;
  assign in_ready = !q_status.full;
  // drop transactions that yield no digits
  assign push     = in_valid && in_ready && (span != '0);

  assign push_job.seq_number = seq_number;
  assign push_job.worker_id  = worker_id;
  assign push_job.gray_cnt   = device_digits;
  assign push_job.count      = (span > CntCap) ? CntCap : span;

endmodule

/* sv/gidu_queue.sv */
`timescale 1ns / 1ps

module gidu_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  gidu_pkg::job_t          push_job,
  input  logic                    pop,
  output gidu_pkg::job_t          head,
  output gidu_pkg::queue_status_t q_status
);
  import gidu_pkg::*;

  localparam int PtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int FillW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0]  PtrLast = PtrW'(QueueDepth - 1);
  localparam logic [FillW-1:0] FillMax = FillW'(QueueDepth);

  job_t             mem [QueueDepth];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [FillW-1:0] fill;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  assign head           = mem[rd_ptr];
  assign q_status.full  = (fill == FillMax);
  assign q_status.empty = (fill == '0);

endmodule

/* sv/gidu_back.sv */
`timescale 1ns / 1ps

module gidu_back (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [7:0]              radix,
  input  gidu_pkg::queue_status_t q_status,
  input  gidu_pkg::job_t          head,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [7:0]              digit_value,
  output logic [3:0]              digit_position,
  output logic                    last_digit
);
  import gidu_pkg::*;

  localparam int StepW = (DivSteps > 1) ? $clog2(DivSteps) : 1;
  localparam logic [StepW-1:0] StepLast = StepW'(DivSteps - 1);

  typedef enum logic {Idle, Run} state_t;

  state_t                 state;
  logic [SeqWidth-1:0]    num;
  logic [DigitWidth-1:0]  rem;
  logic [StepW-1:0]       step;
  logic [CountWidth-1:0]  k;
  logic [CountWidth-1:0]  gray_cnt;
  logic [CountWidth-1:0]  count;
  logic [WorkerWidth-1:0] wid;

  logic [DigitWidth-1:0]  base;
  logic [SeqWidth-1:0]    num_div;
  logic [DigitWidth-1:0]  rem_div;
  logic [DigitWidth-1:0]  digit;
  logic [CountWidth-1:0]  k_inc;
  logic [SeqWidth-1:0]    num_load;
  logic [SeqWidth-1:0]    num_cont;
  logic                   in_gray;
  logic                   fin;
  logic                   advance;
  logic                   last;

  assign base = (radix == '0) ? 8'd1 : radix;

  // restoring division, DivBitsPerCycle quotient bits per cycle
  always_comb begin
    logic [DigitWidth:0]   r9;
    logic [DigitWidth-1:0] r;
    logic [SeqWidth-1:0]   n;
    r = rem;
    n = num;
    for (int i = 0; i < DivBitsPerCycle; i++) begin
      r9 = {r, n[SeqWidth-1]};
      if (r9 >= {1'b0, base}) begin
        r = DigitWidth'(r9 - {1'b0, base});
        n = {n[SeqWidth-2:0], 1'b1};
      end else begin
        r = r9[DigitWidth-1:0];
        n = {n[SeqWidth-2:0], 1'b0};
      end
    end
    num_div = n;
    rem_div = r;
  end

  assign in_gray = (k < gray_cnt);
  assign digit   = (in_gray && num_div[0]) ? (base - rem_div - 8'd1) : rem_div;
  assign k_inc   = k + 1'b1;
  assign last    = (k_inc == count);
  assign fin     = (state == Run) && (step == StepLast);
  assign advance = fin && (!out_valid || out_ready);
  assign pop     = !q_status.empty && ((state == Idle) || (advance && last));

  assign num_load = (head.gray_cnt != '0) ? head.seq_number
                                          : {{(SeqWidth-WorkerWidth){1'b0}}, head.worker_id};
  assign num_cont = (!in_gray || (k_inc < gray_cnt)) ? num_div
                                                     : {{(SeqWidth-WorkerWidth){1'b0}}, wid};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= Idle;
      out_valid <= 1'b0;
      step      <= '0;
    end else begin
      if (out_valid && out_ready && !advance) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        state    <= Run;
        num      <= num_load;
        rem      <= '0;
        step     <= '0;
        k        <= '0;
        gray_cnt <= head.gray_cnt;
        count    <= head.count;
        wid      <= head.worker_id;
      end
      case (state)
        Idle: begin
        end
        Run: begin
          if (!fin) begin
            num  <= num_div;
            rem  <= rem_div;
            step <= step + 1'b1;
          end else if (advance) begin
            out_valid      <= 1'b1;
            digit_value    <= digit;
            digit_position <= k;
            last_digit     <= last;
            if (!last) begin
              k    <= k_inc;
              num  <= num_cont;
              rem  <= '0;
              step <= '0;
            end else if (!pop) begin
              state <= Idle;
            end
          end
        end
        default: state <= Idle;
      endcase
    end
  end

  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == Run) |-> (k < count))
    else $error("digit index beyond digit count");

  a_no_early_exit: assert property (@(posedge clk) disable iff (rst)
    (state == Run && step != StepLast) |=> (state == Run))
    else $error("left run state in the middle of a division");

  a_pop_when_free: assert property (@(posedge clk) disable iff (rst)
    pop |-> (state == Idle) || (advance && last))
    else $error("queue popped while a transaction is in flight");

endmodule

/* sv/mixed_radix_gray_index_decode_unit.sv */
`timescale 1ns / 1ps

// Splits each input transaction (seq_number, worker_id) into one output
// transaction per digit: device_digits reflected mixed-radix Gray digits of
// seq_number, then the remaining plain base-radix digits of worker_id, least
// significant first, with last_digit on the final one. Each digit comes from
// the shared restoring divider, eight quotient bits a cycle over a 32-bit
// dividend unless a finished digit is held back by a stalled output. A
// two-entry queue between the front end and the digit sequencer lets new
// inputs be taken while digits are produced and while a digit waits in the
// output register. An item whose digit count is zero is accepted but
// produces no output. Write configuration only while the unit is idle.
module mixed_radix_gray_index_decode_unit #(
  parameter int MAX_DIGITS = gidu_pkg::MaxDigitsDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  gidu_pkg::cfg_index_t cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [31:0]          seq_number,
  input  logic [9:0]           worker_id,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           digit_value,
  output logic [3:0]           digit_position,
  output logic                 last_digit
);
  import gidu_pkg::*;

  logic [7:0]    radix;
  logic [3:0]    device_digits;
  logic [3:0]    total_digits;
  logic          push;
  logic          pop;
  job_t          push_job;
  job_t          head;
  queue_status_t q_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix         <= 8'd26;
      device_digits <= 4'd7;
      total_digits  <= 4'd8;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CfgRadix:        radix         <= cfg_data;
        CfgDeviceDigits: device_digits <= cfg_data[3:0];
        CfgTotalDigits:  total_digits  <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  gidu_front #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .seq_number   (seq_number),
    .worker_id    (worker_id),
    .device_digits(device_digits),
    .total_digits (total_digits),
    .q_status     (q_status),
    .push         (push),
    .push_job     (push_job)
  );

  gidu_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_job(push_job),
    .pop     (pop),
    .head    (head),
    .q_status(q_status)
  );

  gidu_back u_back (
    .clk           (clk),
    .rst           (rst),
    .radix         (radix),
    .q_status      (q_status),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .digit_value   (digit_value),
    .digit_position(digit_position),
    .last_digit    (last_digit)
  );

endmodule

/* sim/digit_stream_monitor.sv */
`timescale 1ns / 1ps

module digit_stream_monitor (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  gidu_pkg::cfg_index_t cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [31:0]          seq_number,
  input  logic [9:0]           worker_id,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [7:0]           digit_value,
  input  logic [3:0]           digit_position,
  input  logic                 last_digit,
  output int unsigned          mismatch_count,
  output int unsigned          digits_pending,
  output int unsigned          digits_compared
);
  import gidu_pkg::*;

  typedef struct packed {
    logic [7:0] value;
    logic [3:0] position;
    logic       last;
  } digit_t;

  logic [7:0]  radix_reg = 8'd26;
  logic [3:0]  device_reg = 4'd7;
  logic [3:0]  total_reg = 4'd8;
  digit_t      expected_digits[$];
  digit_t      head;
  int unsigned mismatches = 0;
  int unsigned compared = 0;

  function automatic void predict_digits(input logic [31:0] seq, input logic [9:0] wid);
    int unsigned base;
    int unsigned gray_n;
    int unsigned plain_n;
    int unsigned n;
    logic [31:0] s;
    logic [31:0] quot;
    logic [31:0] rem;
    logic [9:0]  w;
    digit_t      d;
    base = (radix_reg == 8'd0) ? 1 : radix_reg;
    gray_n = device_reg;
    plain_n = (total_reg > device_reg) ? total_reg - device_reg : 0;
    n = gray_n + plain_n;
    if (n > MaxDigitsDefault) n = MaxDigitsDefault;
    s = seq;
    w = wid;
    for (int unsigned k = 0; k < n; k++) begin
      if (k < gray_n) begin
        quot = s / base;
        rem = s % base;
        d.value = quot[0] ? 8'(base - rem - 1) : rem[7:0];
        s = quot;
      end else begin
        d.value = 8'(w % base);
        w = 10'(w / base);
      end
      d.position = 4'(k);
      d.last = (k + 1 == n);
      expected_digits.insert(expected_digits.size(), d);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      radix_reg <= 8'd26;
      device_reg <= 4'd7;
      total_reg <= 4'd8;
      expected_digits.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CfgRadix:        radix_reg <= cfg_data;
          CfgDeviceDigits: device_reg <= cfg_data[3:0];
          CfgTotalDigits:  total_reg <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_digits(seq_number, worker_id);
      if (out_valid && out_ready) begin
        if (expected_digits.size() == 0) begin
          mismatches++;
          $error("digit at position %0d arrived with no transaction pending", digit_position);
        end else begin
          head = expected_digits.pop_front();
          compared++;
          if (digit_value !== head.value) begin
            mismatches++;
            $error("digit_value: expected %0d, got %0d", head.value, digit_value);
          end
          if (digit_position !== head.position) begin
            mismatches++;
            $error("digit_position: expected %0d, got %0d", head.position, digit_position);
          end
          if (last_digit !== head.last) begin
            mismatches++;
            $error("last_digit: expected %0d, got %0d", head.last, last_digit);
          end
        end
      end
    end
    mismatch_count <= mismatches;
    digits_pending <= expected_digits.size();
    digits_compared <= compared;
  end

endmodule

/* sim/mixed_radix_gray_index_decode_unit_test.sv */
`timescale 1ns / 1ps

module mixed_radix_gray_index_decode_unit_test;
  import gidu_pkg::*;

  localparam cfg_index_t CfgSpare = 2'd3;
  localparam int ItemTarget = 460;
  localparam int IdleLimit = 3000;
  localparam int DrainCycles = 80;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  cfg_index_t  cfg_index = CfgRadix;
  logic [7:0]  cfg_data = 8'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] seq_number = 32'd0;
  logic [9:0]  worker_id = 10'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  digit_value;
  logic [3:0]  digit_position;
  logic        last_digit;

  int unsigned mismatch_count;
  int unsigned digits_pending;
  int unsigned digits_compared;

  bit          no_gaps = 1'b0;
  int unsigned ready_hold = 0;
  int unsigned idle_cycles = 0;
  int unsigned items_sent = 0;
  int unsigned settings = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  mixed_radix_gray_index_decode_unit uut (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .seq_number     (seq_number),
    .worker_id      (worker_id),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .digit_value    (digit_value),
    .digit_position (digit_position),
    .last_digit     (last_digit)
  );

  digit_stream_monitor monitor (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .seq_number      (seq_number),
    .worker_id       (worker_id),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .digit_value     (digit_value),
    .digit_position  (digit_position),
    .last_digit      (last_digit),
    .mismatch_count  (mismatch_count),
    .digits_pending  (digits_pending),
    .digits_compared (digits_compared)
  );

  function automatic int unsigned draw_gap();
    return no_gaps ? 0 : $urandom_range(0, 10);
  endfunction

  function automatic logic [31:0] pick_seq();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 4095);
      2: return 32'hFFFF_FFFF - $urandom_range(0, 4095);
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  function automatic logic [7:0] pick_radix();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd2;
      3: return 8'd255;
      4, 5: return 8'($urandom_range(3, 16));
      default: return 8'($urandom_range(2, 255));
    endcase
  endfunction

  always @(posedge clk) begin : ready_gen
    int unsigned g;
    if (rst) begin
      out_ready <= 1'b0;
      ready_hold <= 0;
    end else if (out_ready) begin
      if (out_valid) begin
        g = draw_gap();
        ready_hold <= g;
        if (g != 0) out_ready <= 1'b0;
      end
    end else if (ready_hold > 1) begin
      ready_hold <= ready_hold - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IdleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(input logic [31:0] s, input logic [9:0] w);
    int unsigned g;
    g = draw_gap();
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    seq_number <= s;
    worker_id <= w;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (digits_pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [7:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic [7:0] r, input logic [3:0] dd, input logic [3:0] td);
    settle();
    write_reg(CfgRadix, r);
    write_reg(CfgDeviceDigits, {4'($urandom_range(0, 15)), dd});
    write_reg(CfgTotalDigits, {4'($urandom_range(0, 15)), td});
    if ($urandom_range(0, 3) == 0) write_reg(CfgSpare, 8'($urandom));
    cfg_wr_en <= 1'b0;
    settings++;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    send_item(32'h0000_0000, 10'h000);
    send_item(32'hFFFF_FFFF, 10'h3FF);
    send_item(32'hAAAA_AAAA, 10'h155);
    send_item(32'h5555_5555, 10'h2AA);
    apply_setting(8'd255, 4'd15, 4'd15);
    send_item(32'hFFFF_FFFF, 10'h3FF);
    send_item(32'h1234_5678, 10'h000);
    apply_setting(8'd2, 4'd15, 4'd3);
    send_item(32'hFFFF_FFFF, 10'h3FF);
    send_item(32'hAAAA_AAAA, 10'h000);
    apply_setting(8'd0, 4'd3, 4'd9);
    send_item(32'h8765_4321, 10'h3FF);
    apply_setting(8'd1, 4'd2, 4'd5);
    send_item(32'h8000_0001, 10'h200);
    apply_setting(8'd26, 4'd0, 4'd0);
    send_item(32'hFFFF_FFFF, 10'h3FF);
    send_item(32'h0000_0001, 10'h001);
    apply_setting(8'd2, 4'd0, 4'd15);
    send_item(32'h0000_0000, 10'h3FF);
    apply_setting(8'd255, 4'd0, 4'd15);
    send_item(32'h0000_0000, 10'h3FF);
    apply_setting(8'd3, 4'd15, 4'd0);
    send_item(32'hFFFF_FFFF, 10'h000);
    apply_setting(8'd10, 4'd9, 4'd1);
    send_item(32'hFFFF_FFFF, 10'h155);

    while (items_sent < ItemTarget) begin
      apply_setting(pick_radix(), 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
      no_gaps = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(10, 40)) send_item(pick_seq(), 10'($urandom_range(0, 1023)));
    end

    no_gaps = 1'b0;
    settle();
    $display("Compared %0d digits from %0d items over %0d register settings,",
             digits_compared, items_sent, settings);
    $display("radix 0 to 255, Gray and plain digit counts 0 to 15, gaps and stalls 0 to 10.");
    if (mismatch_count == 0 && digits_pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/gidu_pkg.sv
sv/gidu_front.sv
sv/gidu_queue.sv
sv/gidu_back.sv
sv/mixed_radix_gray_index_decode_unit.sv
sim/digit_stream_monitor.sv
sim/mixed_radix_gray_index_decode_unit_test.sv
